// File: rtl/keyword_token_counter_macros.svh
// ----------------------------------------------------------------------------
// keyword_token_counter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_COUNTER_MACROS_SVH
`define KEYWORD_TOKEN_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
`define KTC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("keyword_token_counter assertion failed");
`define KTC_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("keyword_token_counter forbidden condition");
`else
`define KTC_ASSERT(label, clk, rst_n, prop)
`define KTC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/ktc_pkg.sv
// ----------------------------------------------------------------------------
// ktc_pkg
// Types, constants and keyword table of the keyword token counter.
// ----------------------------------------------------------------------------
package ktc_pkg;

	localparam int MAX_WORD_LEN = 99;
	localparam int NUM_KEYWORDS = 11;
	localparam int PREFIX_LEN   = 8;
	localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
	localparam int IDX_W        = 4;
	localparam int CNT_W        = 31;
	localparam int WORD_W       = 8 * PREFIX_LEN;

	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_KEYWORDS-1:0] kw_vec_t;

	localparam logic [1:0] OP_CHAR  = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam len_t MAX_LEN_V  = len_t'(MAX_WORD_LEN);
	localparam len_t PREFIX_LEN_V = len_t'(PREFIX_LEN);
	localparam idx_t NUM_KW_V   = idx_t'(NUM_KEYWORDS);
	localparam cnt_t COUNT_MAX  = {CNT_W{1'b1}};

	// Keyword text, right aligned: last character in the low byte.
	function automatic word_t kw_text(input idx_t k);
		case (k)
			4'd0:    return word_t'("auto");
			4'd1:    return word_t'("break");
			4'd2:    return word_t'("case");
			4'd3:    return word_t'("char");
			4'd4:    return word_t'("const");
			4'd5:    return word_t'("continue");
			4'd6:    return word_t'("default");
			4'd7:    return word_t'("unsigned");
			4'd8:    return word_t'("void");
			4'd9:    return word_t'("volatile");
			4'd10:   return word_t'("while");
			default: return '0;
		endcase
	endfunction

	function automatic len_t kw_len(input idx_t k);
		case (k)
			4'd0:    return len_t'(4);
			4'd1:    return len_t'(5);
			4'd2:    return len_t'(4);
			4'd3:    return len_t'(4);
			4'd4:    return len_t'(5);
			4'd5:    return len_t'(8);
			4'd6:    return len_t'(7);
			4'd7:    return len_t'(8);
			4'd8:    return len_t'(4);
			4'd9:    return len_t'(8);
			4'd10:   return len_t'(5);
			default: return '0;
		endcase
	endfunction

	function automatic kw_vec_t kw_match(input word_t word, input len_t len);
		kw_vec_t m;
		m = '0;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			m[k] = (len == kw_len(idx_t'(k))) && (word == kw_text(idx_t'(k)));
		end
		return m;
	endfunction

	function automatic idx_t kw_encode(input kw_vec_t m);
		idx_t idx;
		idx = '0;
		for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
			if (m[k]) begin
				idx = idx_t'(k);
			end
		end
		return idx;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

// File: rtl/keyword_token_counter.sv
// ----------------------------------------------------------------------------
// keyword_token_counter
// Groups a byte stream into words and counts hits on eleven C keywords.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output side does not stall and
// returns one result per transaction via the first stage and output
// registers. Word assembly and keyword compare happen at acceptance; the
// counts live in an eleven-entry memory with a registered read; a count is
// read at acceptance and written back as its transaction leaves the first
// stage, with the last write forwarded to a later one on the same keyword.
// Counts are zero after reset with no clearing pass and saturate at 2^31-1.
`include "keyword_token_counter_macros.svh"

module keyword_token_counter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  logic [7:0]             ch,
	input  ktc_pkg::idx_t          keyword_index,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   word_ended,
	output logic                   keyword_hit,
	output ktc_pkg::idx_t          matched_index,
	output ktc_pkg::cnt_t          count_value
);

	logic                     in_word_q;
	ktc_pkg::len_t            word_len_q;
	ktc_pkg::word_t           word_q;

	logic                     s1_v_q;
	logic                     s1_end_q;
	logic                     s1_hit_q;
	logic                     s1_rd_q;
	ktc_pkg::idx_t            s1_idx_q;

	ktc_pkg::cnt_t            cnt_mem [ktc_pkg::NUM_KEYWORDS];
	ktc_pkg::cnt_t            rdata_q;
	logic [ktc_pkg::NUM_KEYWORDS-1:0] vld_q;
	logic                     fwd_v_q;
	ktc_pkg::idx_t            fwd_addr_q;
	ktc_pkg::cnt_t            fwd_data_q;

	logic                     out_valid_q;

	logic                     in_acc;
	logic                     s1_adv;
	logic                     alnum;
	logic                     fin;
	logic                     in_word_d;
	ktc_pkg::len_t            len_d;
	ktc_pkg::word_t           word_d;
	ktc_pkg::len_t            cand_len;
	ktc_pkg::word_t           cand_word;
	ktc_pkg::kw_vec_t         match;
	ktc_pkg::idx_t            hit_idx;
	logic                     hit;
	logic                     rd_ok;
	logic                     rd_en;
	ktc_pkg::idx_t            rd_addr;
	ktc_pkg::cnt_t            cur;
	ktc_pkg::cnt_t            inc;
	logic                     wr_en;

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !s1_v_q || s1_adv;
	assign in_acc   = in_valid && in_ready;
	assign alnum    = ktc_pkg::is_letter(ch) || ktc_pkg::is_digit(ch);

	always_comb begin
		in_word_d = in_word_q;
		len_d     = word_len_q;
		word_d    = word_q;
		cand_len  = word_len_q;
		cand_word = word_q;
		fin       = 1'b0;
		case (operation)
			ktc_pkg::OP_CHAR: begin
				if (in_word_q) begin
					if (alnum) begin
						cand_len = word_len_q + ktc_pkg::len_t'(1);
						if (word_len_q < ktc_pkg::PREFIX_LEN_V) begin
							cand_word = {word_q[ktc_pkg::WORD_W-9:0], ch};
						end
						len_d  = cand_len;
						word_d = cand_word;
						fin    = (cand_len >= ktc_pkg::MAX_LEN_V);
					end else begin
						fin = 1'b1;
					end
				end else if (ktc_pkg::is_letter(ch)) begin
					in_word_d = 1'b1;
					len_d     = ktc_pkg::len_t'(1);
					word_d    = {{(ktc_pkg::WORD_W-8){1'b0}}, ch};
				end
			end
			ktc_pkg::OP_FLUSH: begin
				fin = in_word_q;
			end
			default: begin
			end
		endcase
		if (fin) begin
			in_word_d = 1'b0;
			len_d     = '0;
		end
	end

	assign match   = ktc_pkg::kw_match(cand_word, cand_len);
	assign hit     = fin && (|match);
	assign hit_idx = ktc_pkg::kw_encode(match);
	assign rd_ok   = (operation == ktc_pkg::OP_READ) && (keyword_index < ktc_pkg::NUM_KW_V);
	assign rd_en   = in_acc && (hit || rd_ok);
	assign rd_addr = hit ? hit_idx : keyword_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q  <= 1'b0;
			word_len_q <= '0;
		end else if (in_acc) begin
			in_word_q  <= in_word_d;
			word_len_q <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_ready) begin
			s1_v_q <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_end_q <= fin;
			s1_hit_q <= hit;
			s1_rd_q  <= rd_ok;
			if (hit) begin
				s1_idx_q <= hit_idx;
			end else if (operation == ktc_pkg::OP_READ) begin
				s1_idx_q <= keyword_index;
			end else begin
				s1_idx_q <= '0;
			end
		end
	end

	assign cur = (fwd_v_q && (fwd_addr_q == s1_idx_q)) ? fwd_data_q :
		(vld_q[s1_idx_q] ? rdata_q : '0);
	assign inc   = (cur == ktc_pkg::COUNT_MAX) ? cur : cur + ktc_pkg::cnt_t'(1);
	assign wr_en = s1_v_q && s1_adv && s1_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnt_mem[s1_idx_q] <= inc;
		end
		if (rd_en) begin
			rdata_q <= cnt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			vld_q[s1_idx_q] <= 1'b1;
			fwd_v_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= s1_idx_q;
			fwd_data_q <= inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_v_q) begin
			word_ended    <= s1_end_q;
			keyword_hit   <= s1_hit_q;
			matched_index <= s1_idx_q;
			if (s1_hit_q) begin
				count_value <= inc;
			end else if (s1_rd_q) begin
				count_value <= cur;
			end else begin
				count_value <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`KTC_ASSERT(a_word_len_range, clk, arst_n, in_word_q |-> (word_len_q != '0) && (word_len_q < ktc_pkg::MAX_LEN_V))
	`KTC_ASSERT(a_accept_fills_s1, clk, arst_n, in_acc |=> s1_v_q)
	`KTC_ASSERT(a_write_shows_hit, clk, arst_n, wr_en |=> out_valid_q && keyword_hit && (count_value == fwd_data_q))
	`KTC_ASSERT_NEVER(a_hit_without_end, clk, arst_n, out_valid_q && keyword_hit && !word_ended)

endmodule
